// ----- hdl/aal_pkg.sv -----
// shared types, constants and helpers for the antialiased line rasterizer
package aal_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 16;
  // fraction bits of the error accumulator and step
  localparam int FRAC_BITS = 16;
  // width of one coverage weight
  localparam int WEIGHT_BITS = 8;
  // largest number of weight bits taken from the accumulator
  localparam int MAX_INTENSITY = 8;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTENSITY = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CMASK     = 1'd1;
  localparam int CFG_DATA_BITS = 8;

  // item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // line flag bit positions
  localparam int FL_ACTIVE = 0;
  localparam int FL_XPOS   = 1;
  localparam int FL_XMAJOR = 2;
  localparam int FL_AA     = 3;

  // input item
  typedef struct packed {
    logic               func;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x_in;
    logic signed [15:0] end_y_in;
  } item_t;

  // result item
  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]         coverage_weight;
    logic               line_done;
  } pixel_t;

  // top bits of the accumulator, with the bit count clamped to 1..8
  function automatic logic [WEIGHT_BITS-1:0] coverage(input logic [FRAC_BITS-1:0] acc,
                                                      input logic [3:0] bits);
    logic [3:0]           b;
    logic [4:0]           sh;
    logic [FRAC_BITS-1:0] s;
    b = bits;
    if (b == 4'd0) begin
      b = 4'd1;
    end else if (b > 4'(MAX_INTENSITY)) begin
      b = 4'(MAX_INTENSITY);
    end
    sh = 5'(FRAC_BITS) - {1'b0, b};
    s = acc >> sh;
    return s[WEIGHT_BITS-1:0];
  endfunction

endpackage

// ----- hdl/aal_div.sv -----
// bit-serial restoring divider for the fractional error step
module aal_div #(
  parameter int COORD_BITS = aal_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [COORD_BITS-1:0]      numer,
  input  logic [COORD_BITS-1:0]      denom,
  output logic                       done,
  output logic [aal_pkg::FRAC_BITS-1:0] quot
);
  import aal_pkg::*;

  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] den;
  logic [COORD_BITS:0]   rem_sh;
  logic [COORD_BITS:0]   rem_diff;
  logic                  fits;

  // one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, 1'b0};
    rem_diff = rem_sh - {1'b0, den};
    fits     = rem_sh >= {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer;
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_diff[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
      quot <= {quot[FRAC_BITS-2:0], fits};
    end
  end

endmodule

// ----- hdl/aal_core.sv -----
// line setup, walk sequencer and output register
module aal_core #(
  parameter int COORD_BITS = aal_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  aal_pkg::item_t                item,
  output logic                          pixel_valid,
  input  logic                          pixel_stall,
  output aal_pkg::pixel_t               pixel,
  input  logic [3:0]                    intensity_bits,
  input  logic [7:0]                    complement_mask,
  output logic                          div_start,
  output logic [COORD_BITS-1:0]         div_numer,
  output logic [COORD_BITS-1:0]         div_denom,
  input  logic                          div_done,
  input  logic [aal_pkg::FRAC_BITS-1:0] div_quot
);
  import aal_pkg::*;

  localparam int CB = COORD_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_CLASS = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_FIRST = 4'd4;
  localparam logic [3:0] S_RUN   = 4'd5;
  localparam logic [3:0] S_LAST  = 4'd6;
  localparam logic [3:0] S_AA1   = 4'd7;
  localparam logic [3:0] S_AA2   = 4'd8;

  logic [3:0]           state;
  logic [CB-1:0]        cur_x, cur_y, stop_x, stop_y;
  logic [FRAC_BITS-1:0] error_accum, error_step;
  logic [CB:0]          steps_left;
  logic [3:0]           line_flags;
  logic signed [CB:0]   dx, dy;

  // sign-extend a wrapped coordinate to the port width
  function automatic logic [15:0] to_port(input logic [CB-1:0] v);
    logic signed [CB-1:0] s;
    s = v;
    return 16'(s);
  endfunction

  // one position step along x in the line's x direction
  function automatic logic [CB-1:0] step_x(input logic [CB-1:0] v, input logic xpos);
    return xpos ? v + CB'(1) : v - CB'(1);
  endfunction

  logic out_free;
  logic load;
  pixel_t load_data;

  assign out_free   = !pixel_valid || !pixel_stall;
  assign item_stall = (state != S_IDLE);

  // endpoint swap and deltas
  logic          swap;
  logic [CB-1:0] sx0, sy0, sx1, sy1;
  always_comb begin
    swap = $signed(cur_y) > $signed(stop_y);
    sx0  = swap ? stop_x : cur_x;
    sy0  = swap ? stop_y : cur_y;
    sx1  = swap ? cur_x : stop_x;
    sy1  = swap ? cur_y : stop_y;
  end

  // line classification
  logic [CB-1:0] adx, ady, major, minor;
  logic          is_run, xmaj;
  logic [CB:0]   class_steps;
  always_comb begin
    adx    = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady    = dy[CB-1:0];
    xmaj   = adx > ady;
    major  = xmaj ? adx : ady;
    minor  = xmaj ? ady : adx;
    is_run = (ady == '0) || (adx == '0) || (adx == ady);
    if (is_run) begin
      class_steps = (major == '0) ? '0 : {1'b0, major - CB'(1)};
    end else begin
      class_steps = {1'b0, major};
    end
  end

  assign div_start = (state == S_CLASS) && !is_run;
  assign div_numer = minor;
  assign div_denom = major;

  // walk arithmetic
  logic [FRAC_BITS-1:0] acc_n;
  logic                 adv;
  logic [CB-1:0]        run_x, run_y, aa_x, aa_y;
  logic [CB:0]          steps_dec;
  logic [7:0]           w_new, w_cur;
  always_comb begin
    acc_n     = error_accum + error_step;
    adv       = acc_n <= error_accum;
    steps_dec = steps_left - (CB+1)'(1);
    run_x     = (cur_x != stop_x) ? step_x(cur_x, line_flags[FL_XPOS]) : cur_x;
    run_y     = (cur_y != stop_y) ? cur_y + CB'(1) : cur_y;
    if (line_flags[FL_XMAJOR]) begin
      aa_x = step_x(cur_x, line_flags[FL_XPOS]);
      aa_y = adv ? cur_y + CB'(1) : cur_y;
    end else begin
      aa_x = adv ? step_x(cur_x, line_flags[FL_XPOS]) : cur_x;
      aa_y = cur_y + CB'(1);
    end
    w_new = coverage(acc_n, intensity_bits);
    w_cur = coverage(error_accum, intensity_bits);
  end

  // pixel to load into the output register
  always_comb begin
    load      = 1'b0;
    load_data = '0;
    case (state)
      S_FIRST: begin
        load      = out_free;
        load_data = '{to_port(cur_x), to_port(cur_y), 8'd0, steps_left == '0};
      end
      S_RUN: begin
        load      = out_free;
        load_data = '{to_port(run_x), to_port(run_y), 8'd0, steps_dec == '0};
      end
      S_LAST: begin
        load      = out_free;
        load_data = '{to_port(stop_x), to_port(stop_y), 8'd0, 1'b1};
      end
      S_AA1: begin
        load      = out_free;
        load_data = '{to_port(aa_x), to_port(aa_y), w_new, 1'b0};
      end
      S_AA2: begin
        load = out_free;
        if (line_flags[FL_XMAJOR]) begin
          load_data = '{to_port(cur_x), to_port(cur_y + CB'(1)),
                        w_cur ^ complement_mask, 1'b0};
        end else begin
          load_data = '{to_port(step_x(cur_x, line_flags[FL_XPOS])), to_port(cur_y),
                        w_cur ^ complement_mask, 1'b0};
        end
      end
      default: begin
        load      = 1'b0;
        load_data = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (load) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel <= load_data;
    end
  end

  // sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_x       <= '0;
      cur_y       <= '0;
      stop_x      <= '0;
      stop_y      <= '0;
      error_accum <= '0;
      error_step  <= '0;
      steps_left  <= '0;
      line_flags  <= '0;
      dx          <= '0;
      dy          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.func == FUNC_START) begin
              cur_x  <= item.start_x[CB-1:0];
              cur_y  <= item.start_y[CB-1:0];
              stop_x <= item.end_x_in[CB-1:0];
              stop_y <= item.end_y_in[CB-1:0];
              state  <= S_LOAD;
            end else if (!line_flags[FL_ACTIVE] || steps_left == '0) begin
              line_flags <= '0;
            end else if (!line_flags[FL_AA]) begin
              state <= S_RUN;
            end else if (steps_left == (CB+1)'(1)) begin
              state <= S_LAST;
            end else begin
              state <= S_AA1;
            end
          end
        end
        S_LOAD: begin
          cur_x  <= sx0;
          cur_y  <= sy0;
          stop_x <= sx1;
          stop_y <= sy1;
          dx     <= {sx1[CB-1], sx1} - {sx0[CB-1], sx0};
          dy     <= {sy1[CB-1], sy1} - {sy0[CB-1], sy0};
          state  <= S_CLASS;
        end
        S_CLASS: begin
          error_accum <= '0;
          error_step  <= '0;
          steps_left  <= class_steps;
          if (class_steps == '0) begin
            line_flags <= '0;
          end else begin
            line_flags[FL_ACTIVE] <= 1'b1;
            line_flags[FL_XPOS]   <= !dx[CB];
            line_flags[FL_XMAJOR] <= !is_run && xmaj;
            line_flags[FL_AA]     <= !is_run;
          end
          state <= is_run ? S_FIRST : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            error_step <= div_quot;
            state      <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (out_free) begin
            cur_x      <= run_x;
            cur_y      <= run_y;
            steps_left <= steps_dec;
            if (steps_dec == '0) begin
              line_flags <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_LAST: begin
          if (out_free) begin
            steps_left <= '0;
            line_flags <= '0;
            state      <= S_IDLE;
          end
        end
        S_AA1: begin
          if (out_free) begin
            error_accum <= acc_n;
            cur_x       <= aa_x;
            cur_y       <= aa_y;
            steps_left  <= steps_dec;
            state       <= S_AA2;
          end
        end
        S_AA2: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the output register is never overwritten while a pixel waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!pixel_valid || !pixel_stall))
    else $error("output pixel overwritten while stalled");

  // the final pixel of a line leaves the line inactive
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (load && load_data.line_done) |=> !line_flags[FL_ACTIVE])
    else $error("line still active after its final pixel");

  // an active line always has steps to come between items
  a_active_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && line_flags[FL_ACTIVE]) |-> (steps_left != '0))
    else $error("active line with no steps left");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the division wait");

endmodule

// ----- hdl/antialiased_line_rasterizer_top.sv -----
// top level of the antialiased line rasterizer: configuration registers and unit wiring
//
// Antialiased line rasterizer, pixel generation only. A start item (func 0) loads two
// endpoints and returns the one with the smaller y at a coverage weight of zero; a step
// item (func 1) returns one pixel for horizontal, vertical and diagonal runs and for the
// end point, or two pixels that straddle the line for a general line. One item is in
// work at a time and the input is stalled meanwhile; the output register lets the next
// item be taken while a result still waits. A start item passes through load and
// classification, and for a general line waits on the bit-serial divider that forms the
// 16-bit error step one quotient bit per cycle, before its pixel is loaded. A step item
// that gives a pair sends its pixels one after the other through the single output
// register, which holds one pixel at a time. Output stalls hold the sequencer.
module antialiased_line_rasterizer_top #(
  parameter int COORD_BITS = aal_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  aal_pkg::item_t                     item,
  output logic                               pixel_valid,
  input  logic                               pixel_stall,
  output aal_pkg::pixel_t                    pixel,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aal_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [aal_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import aal_pkg::*;

  logic [3:0]           intensity_bits;
  logic [7:0]           complement_mask;
  logic                 div_start;
  logic                 div_done;
  logic [COORD_BITS-1:0] div_numer;
  logic [COORD_BITS-1:0] div_denom;
  logic [FRAC_BITS-1:0] div_quot;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_bits  <= 4'd8;
      complement_mask <= 8'd254;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INTENSITY: intensity_bits  <= cfg_data[3:0];
        REG_CMASK:     complement_mask <= cfg_data[7:0];
        default: begin
          intensity_bits <= intensity_bits;
        end
      endcase
    end
  end

  // error step divider
  aal_div #(
    .COORD_BITS(COORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer and walk
  aal_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .pixel           (pixel),
    .intensity_bits  (intensity_bits),
    .complement_mask (complement_mask),
    .div_start       (div_start),
    .div_numer       (div_numer),
    .div_denom       (div_denom),
    .div_done        (div_done),
    .div_quot        (div_quot)
  );

endmodule
